/* rtl/wgts_pkg.sv */
// Package for the wave grid time step core.
// Holds request and result types, register map, reset values and the
// saturating helper. Depends on nothing.
package wgts_pkg;

    typedef logic signed [31:0] t_word;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_STEP = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic [5:0]         column;
        logic [5:0]         row;
        logic signed [31:0] displacement;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] cell_position;
        logic               step_done;
        logic               saturated;
    } t_out_res;

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [1:0] REG_GAIN     = 2'd0;
    localparam logic [1:0] REG_TIMESTEP = 2'd1;
    localparam logic [1:0] REG_BOUNDARY = 2'd2;

    localparam logic [31:0] GAIN_RESET     = 32'd65536;
    localparam logic [15:0] TIMESTEP_RESET = 16'd6554;
    localparam logic        BOUNDARY_RESET = 1'b1;

    typedef struct packed {
        logic  clip;
        t_word val;
    } t_sat;

    // Clip a wide signed value to the signed 32-bit range.
    function automatic t_sat sat32(input logic signed [63:0] x);
        t_sat r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end else begin
            r.clip = 1'b0;
            r.val  = x[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/wgts_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Used for every cell store of the wave grid core. No dependencies.
module wgts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/wave_grid_time_step_core.sv */
// Top level of the wave grid time step core.
// Depends on wgts_pkg (types, register map, sat32) and wgts_ram (cell stores).
//
// The core keeps position, velocity and acceleration of every grid cell in
// three RAMs and handles one request at a time. After reset it runs a
// clearing pass that zeroes all three stores; no request is taken during
// it, though configuration writes are. An add or read request reads the
// cell, then writes back the sum (add only) and captures the result. A
// step request runs the stencil pass (skipped when the boundary register
// is 0) and then the integration pass, each followed by a pipeline drain.
// The stencil pass walks each interior row column by column and reads the
// three positions of a column from the single read port of the position
// RAM, which sets its length; the integration pass streams one cell per
// cycle through all three RAMs. A new request is taken as soon as the
// previous one has produced its result, even if that result still waits
// in the output register.
module wave_grid_time_step_core
    import wgts_pkg::*;
#(
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_res    o_out,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS = GRID_COLUMNS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_COLUMNS);

    localparam logic [AW-1:0] COLS_A     = AW'(GRID_COLUMNS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] FIRST_BASE = AW'(GRID_COLUMNS);
    localparam logic [AW-1:0] LAST_BASE  = AW'((GRID_ROWS - 2) * GRID_COLUMNS);
    localparam logic [CW-1:0] LAST_COL   = CW'(GRID_COLUMNS - 1);
    localparam logic [2:0]    DRAIN_LAST = 3'd6;

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_CELL_RD = 9'b000000100,
        ST_CELL_WB = 9'b000001000,
        ST_P1      = 9'b000010000,
        ST_P1_DRN  = 9'b000100000,
        ST_P2      = 9'b001000000,
        ST_P2_DRN  = 9'b010000000,
        ST_DONE    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [31:0] r_gain;
    logic [15:0] r_dt;
    logic        r_bnd;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_dt   <= TIMESTEP_RESET;
            r_bnd  <= BOUNDARY_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_GAIN:     r_gain <= pwdata;
                REG_TIMESTEP: r_dt   <= pwdata[15:0];
                REG_BOUNDARY: r_bnd  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GAIN:     prdata = r_gain;
            REG_TIMESTEP: prdata = {16'd0, r_dt};
            REG_BOUNDARY: prdata = {31'd0, r_bnd};
            default:      prdata = '0;
        endcase
    end

    // Request holding registers and the pending result.
    t_in_req       r_req;
    logic [AW-1:0] r_addr;
    logic          r_inside;
    logic          r_sat;
    t_word         r_res_pos;
    logic          r_res_done;
    logic          in_acc;
    logic          in_inside;
    logic [AW-1:0] in_addr;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_inside  = (32'(i_in.column) < 32'(GRID_COLUMNS))
                     && (32'(i_in.row) < 32'(GRID_ROWS));
    assign in_addr    = AW'(i_in.row) * COLS_A + AW'(i_in.column);

    // RAM ports.
    logic          pos_we, vel_we, acc_we;
    logic [AW-1:0] pos_wa, vel_wa, acc_wa;
    t_word         pos_wd, vel_wd, acc_wd;
    logic [AW-1:0] pos_ra, va_ra;
    logic [31:0]   pos_rq, vel_rq, acc_rq;
    t_word         pos_rd, vel_rd, acc_rd;

    assign pos_rd = pos_rq;
    assign vel_rd = vel_rq;
    assign acc_rd = acc_rq;

    wgts_ram #(.WIDTH(32), .DEPTH(CELLS)) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (pos_we),
        .i_waddr(pos_wa),
        .i_wdata(pos_wd),
        .i_raddr(pos_ra),
        .o_rdata(pos_rq)
    );

    wgts_ram #(.WIDTH(32), .DEPTH(CELLS)) u_vel_ram (
        .i_clk  (i_clk),
        .i_we   (vel_we),
        .i_waddr(vel_wa),
        .i_wdata(vel_wd),
        .i_raddr(va_ra),
        .o_rdata(vel_rq)
    );

    wgts_ram #(.WIDTH(32), .DEPTH(CELLS)) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (acc_we),
        .i_waddr(acc_wa),
        .i_wdata(acc_wd),
        .i_raddr(va_ra),
        .o_rdata(acc_rq)
    );

    // Sweep counter, shared by the clearing pass and the integration pass.
    logic [AW-1:0] r_k;
    logic [2:0]    r_drain;

    // Stencil pass walker: center row base address, column and phase.
    // Phase 0 reads the row above, 1 the center row, 2 the row below.
    logic [AW-1:0] r_base;
    logic [CW-1:0] r_col;
    logic [1:0]    r_ph;
    logic [AW-1:0] p1_mid;
    logic [AW-1:0] p1_addr;
    logic          p1_col_end;

    assign p1_mid     = r_base + AW'(r_col);
    assign p1_col_end = (r_ph == 2'd2) && (r_col == LAST_COL);

    always_comb begin
        unique case (r_ph)
            2'd0:    p1_addr = p1_mid - COLS_A;
            2'd2:    p1_addr = p1_mid + COLS_A;
            default: p1_addr = p1_mid;
        endcase
    end

    always_comb begin
        priority case (1'b1)
            r_state == ST_P1: pos_ra = p1_addr;
            r_state == ST_P2: pos_ra = r_k;
            default:          pos_ra = r_addr;
        endcase
    end
    assign va_ra = r_k;

    // Stencil pipeline. Stage 1 carries the read just issued; when the
    // bottom value of a column lands, the 3x3 window shifts left by one.
    logic          r_s1_v;
    logic [1:0]    r_s1_ph;
    logic [CW-1:0] r_s1_col;
    logic [AW-1:0] r_s1_ctr;
    t_word         r_ct, r_cm;
    t_word         r_wt [3];
    t_word         r_wm [3];
    t_word         r_wb [3];
    logic          r_s2_v;
    logic [AW-1:0] r_s2_ctr;
    logic          r_s3_v;
    logic [AW-1:0] r_s3_ctr;
    logic signed [35:0] r_s3_diff;
    logic          r_s4_v;
    logic [AW-1:0] r_s4_ctr;
    logic signed [52:0] r_s4_hi, r_s4_lo;
    logic signed [35:0] s2_sum;
    t_sat          s4_acc;

    // Sum of the eight neighbors minus eight times the center, exact.
    assign s2_sum = 36'(r_wt[0]) + 36'(r_wt[1]) + 36'(r_wt[2])
                  + 36'(r_wm[0]) + 36'(r_wm[2])
                  + 36'(r_wb[0]) + 36'(r_wb[1]) + 36'(r_wb[2])
                  - (36'(r_wm[1]) <<< 3);

    // Gain is split into integer and fraction halves; only the fraction
    // product is rounded.
    assign s4_acc = sat32(64'(r_s4_hi) + 64'((r_s4_lo + 53'sd32768) >>> 16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == ST_P1);
            r_s2_v <= r_s1_v && (r_s1_ph == 2'd2)
                   && (r_s1_col != '0) && (r_s1_col != CW'(1));
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ph  <= r_ph;
        r_s1_col <= r_col;
        r_s1_ctr <= p1_mid - AW'(1);
        if (r_s1_v) begin
            unique case (r_s1_ph)
                2'd0: r_ct <= pos_rd;
                2'd1: r_cm <= pos_rd;
                default: begin
                    r_wt[0] <= r_wt[1];
                    r_wt[1] <= r_wt[2];
                    r_wt[2] <= r_ct;
                    r_wm[0] <= r_wm[1];
                    r_wm[1] <= r_wm[2];
                    r_wm[2] <= r_cm;
                    r_wb[0] <= r_wb[1];
                    r_wb[1] <= r_wb[2];
                    r_wb[2] <= pos_rd;
                end
            endcase
        end
        r_s2_ctr  <= r_s1_ctr;
        r_s3_ctr  <= r_s2_ctr;
        r_s3_diff <= s2_sum;
        r_s4_ctr  <= r_s3_ctr;
        r_s4_hi   <= r_s3_diff * $signed({1'b0, r_gain[31:16]});
        r_s4_lo   <= r_s3_diff * $signed({1'b0, r_gain[15:0]});
    end

    // Integration pipeline: velocity first, then position from the new
    // velocity, each product registered before it is used.
    logic          r_q1_v, r_q2_v, r_q3_v, r_q4_v;
    logic [AW-1:0] r_q1_a, r_q2_a, r_q3_a, r_q4_a;
    logic signed [48:0] r_q2_prod, r_q4_prod;
    t_word         r_q2_vel, r_q2_pos, r_q3_pos, r_q4_pos, r_q3_vnew;
    t_sat          q2_vel, q4_pos;

    assign q2_vel = sat32(64'(r_q2_vel) + 64'((r_q2_prod + 49'sd32768) >>> 16));
    assign q4_pos = sat32(64'(r_q4_pos) + 64'((r_q4_prod + 49'sd32768) >>> 16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_v <= 1'b0;
            r_q2_v <= 1'b0;
            r_q3_v <= 1'b0;
            r_q4_v <= 1'b0;
        end else begin
            r_q1_v <= (r_state == ST_P2);
            r_q2_v <= r_q1_v;
            r_q3_v <= r_q2_v;
            r_q4_v <= r_q3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1_a    <= r_k;
        r_q2_a    <= r_q1_a;
        r_q2_prod <= acc_rd * $signed({1'b0, r_dt});
        r_q2_vel  <= vel_rd;
        r_q2_pos  <= pos_rd;
        r_q3_a    <= r_q2_a;
        r_q3_vnew <= q2_vel.val;
        r_q3_pos  <= r_q2_pos;
        r_q4_a    <= r_q3_a;
        r_q4_prod <= r_q3_vnew * $signed({1'b0, r_dt});
        r_q4_pos  <= r_q3_pos;
    end

    // Single-cell add.
    t_sat add_sum;
    assign add_sum = sat32(64'(pos_rd) + 64'(r_req.displacement));

    // Write ports. Each store is written by the clearing pass and by one or
    // two pipelines that never run at the same time.
    always_comb begin
        pos_we = 1'b0;
        pos_wa = r_q4_a;
        pos_wd = q4_pos.val;
        priority if (r_state == ST_CLEAR) begin
            pos_we = 1'b1;
            pos_wa = r_k;
            pos_wd = '0;
        end else if (r_state == ST_CELL_WB && r_req.opcode == OP_ADD) begin
            pos_we = 1'b1;
            pos_wa = r_addr;
            pos_wd = add_sum.val;
        end else if (r_q4_v) begin
            pos_we = 1'b1;
        end
    end

    always_comb begin
        vel_we = 1'b0;
        vel_wa = r_q2_a;
        vel_wd = q2_vel.val;
        priority if (r_state == ST_CLEAR) begin
            vel_we = 1'b1;
            vel_wa = r_k;
            vel_wd = '0;
        end else if (r_q2_v) begin
            vel_we = 1'b1;
        end
    end

    always_comb begin
        acc_we = 1'b0;
        acc_wa = r_s4_ctr;
        acc_wd = s4_acc.val;
        priority if (r_state == ST_CLEAR) begin
            acc_we = 1'b1;
            acc_wa = r_k;
            acc_wd = '0;
        end else if (r_s4_v) begin
            acc_we = 1'b1;
        end
    end

    // Sequencer.
    logic out_free;
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (r_k == LAST_CELL) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    priority if (i_in.opcode == OP_STEP) begin
                        n_state = r_bnd ? ST_P1 : ST_P2;
                    end else if ((i_in.opcode == OP_ADD || i_in.opcode == OP_READ)
                                 && in_inside) begin
                        n_state = ST_CELL_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_CELL_RD: n_state = ST_CELL_WB;
            ST_CELL_WB: n_state = ST_DONE;
            ST_P1:      if (p1_col_end && r_base == LAST_BASE) n_state = ST_P1_DRN;
            ST_P1_DRN:  if (r_drain == DRAIN_LAST) n_state = ST_P2;
            ST_P2:      if (r_k == LAST_CELL) n_state = ST_P2_DRN;
            ST_P2_DRN:  if (r_drain == DRAIN_LAST) n_state = ST_DONE;
            ST_DONE:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= '0;
            r_drain <= '0;
            r_base  <= FIRST_BASE;
            r_col   <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR || r_state == ST_P2) begin
                r_k <= (r_k == LAST_CELL) ? '0 : r_k + AW'(1);
            end
            if (r_state == ST_P1_DRN || r_state == ST_P2_DRN) begin
                r_drain <= (r_drain == DRAIN_LAST) ? '0 : r_drain + 3'd1;
            end
            if (r_state == ST_P1) begin
                if (r_ph == 2'd2) begin
                    r_ph <= '0;
                    if (r_col == LAST_COL) begin
                        r_col  <= '0;
                        r_base <= (r_base == LAST_BASE) ? FIRST_BASE : r_base + COLS_A;
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end else begin
                    r_ph <= r_ph + 2'd1;
                end
            end
        end
    end

    // Request capture and result assembly.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req      <= i_in;
            r_addr     <= in_addr;
            r_inside   <= in_inside;
            r_sat      <= 1'b0;
            r_res_pos  <= '0;
            r_res_done <= (i_in.opcode == OP_STEP);
        end else begin
            if (r_state == ST_CELL_WB) begin
                if (r_req.opcode == OP_ADD) begin
                    r_res_pos <= add_sum.val;
                    r_sat     <= add_sum.clip;
                end else begin
                    r_res_pos <= pos_rd;
                end
            end
            if ((r_s4_v && s4_acc.clip) || (r_q2_v && q2_vel.clip)
                || (r_q4_v && q4_pos.clip)) begin
                r_sat <= 1'b1;
            end
        end
    end

    // Output register: holds one result while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            o_out.cell_position <= r_res_pos;
            o_out.step_done     <= r_res_done;
            o_out.saturated     <= r_sat && r_inside | r_res_done;
        end
    end

    // Acceleration is only written by the stencil pipeline while that
    // pass or its drain is running.
    a_acc_write_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> (r_state == ST_P1 || r_state == ST_P1_DRN))
        else $error("stencil write outside the stencil pass");

    // Both pipelines are empty whenever a result is handed over.
    a_drained_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |-> !r_s1_v && !r_s4_v && !r_q1_v && !r_q4_v)
        else $error("result issued with work still in flight");

    // A step result carries no position.
    a_step_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.step_done) |-> o_out.cell_position == '0)
        else $error("step result with nonzero position");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for wave_grid_time_step_core.
// Depends on wgts_pkg (request and result types, opcodes, register indexes)
// and the core RTL. Random requests and stalls are checked by a grid model.
module tb_top;
    import wgts_pkg::*;

    localparam int COLS       = 64;
    localparam int ROWS       = 64;
    localparam int CELLS      = COLS * ROWS;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_WAIT = 40;

    // The grid model keeps its own copy of every cell and of the three
    // registers, and queues the result that each accepted request produces.
    class grid_tracker;
        int        position_q[CELLS];
        int        velocity_q[CELLS];
        int        accel_q[CELLS];
        bit [31:0] gain;
        bit [15:0] dt;
        bit        boundary_on;
        t_out_res  pending_results[$];
        int        fails;

        function new();
            foreach (position_q[k]) begin
                position_q[k] = 0;
                velocity_q[k] = 0;
                accel_q[k]    = 0;
            end
            gain        = GAIN_RESET;
            dt          = TIMESTEP_RESET;
            boundary_on = BOUNDARY_RESET;
            fails       = 0;
        endfunction

        // Round a Q32.32 product to Q16.16, nearest with ties upward.
        function longint round_q16(longint v);
            return (v + 64'sd32768) >>> 16;
        endfunction

        function int clip_word(longint v, inout bit clipped);
            if (v > 64'sd2147483647) begin
                clipped = 1'b1;
                return 32'h7FFF_FFFF;
            end
            if (v < -64'sd2147483648) begin
                clipped = 1'b1;
                return 32'h8000_0000;
            end
            return int'(v);
        endfunction

        function void write_reg(logic [1:0] idx, bit [31:0] value);
            case (idx)
                REG_GAIN:     gain = value;
                REG_TIMESTEP: dt = value[15:0];
                REG_BOUNDARY: boundary_on = value[0];
                default: ;
            endcase
        endfunction

        // One time step: the stencil pass reads only positions from before
        // the step, then every cell integrates velocity and position.
        function bit advance_grid();
            bit     clipped;
            longint nsum, diff, ghi, glo, dtl;
            int     m;
            clipped = 1'b0;
            ghi = longint'(gain >> 16);
            glo = longint'(gain & 32'hFFFF);
            dtl = longint'(dt);
            if (boundary_on) begin
                for (int r = 1; r < ROWS - 1; r++) begin
                    for (int c = 1; c < COLS - 1; c++) begin
                        m = r * COLS + c;
                        nsum = 0;
                        for (int dr = -1; dr <= 1; dr++)
                            for (int dc = -1; dc <= 1; dc++)
                                if (dr != 0 || dc != 0)
                                    nsum += longint'(position_q[m + dr * COLS + dc]);
                        diff = nsum - 8 * longint'(position_q[m]);
                        accel_q[m] = clip_word(diff * ghi + round_q16(diff * glo),
                                               clipped);
                    end
                end
            end
            for (int k = 0; k < CELLS; k++) begin
                velocity_q[k] = clip_word(longint'(velocity_q[k])
                                + round_q16(longint'(accel_q[k]) * dtl), clipped);
                position_q[k] = clip_word(longint'(position_q[k])
                                + round_q16(longint'(velocity_q[k]) * dtl), clipped);
            end
            return clipped;
        endfunction

        function void note_request(t_in_req req);
            t_out_res res;
            bit       clipped;
            int       m;
            res     = '0;
            clipped = 1'b0;
            m       = int'(req.row) * COLS + int'(req.column);
            case (req.opcode)
                OP_ADD: begin
                    position_q[m] = clip_word(longint'(position_q[m])
                                    + longint'(req.displacement), clipped);
                    res.cell_position = position_q[m];
                    res.saturated     = clipped;
                end
                OP_STEP: begin
                    res.step_done = 1'b1;
                    res.saturated = advance_grid();
                end
                OP_READ: begin
                    res.cell_position = position_q[m];
                end
                default: ;
            endcase
            pending_results = {pending_results, res};
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (pending_results.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: position %0d done %0b sat %0b",
                             got.cell_position, got.step_done, got.saturated);
                return;
            end
            want = pending_results.pop_front();
            if (got.cell_position !== want.cell_position ||
                got.step_done !== want.step_done ||
                got.saturated !== want.saturated) begin
                fails++;
                if (fails <= 10)
                    $display({"result differs: expected position %0d done %0b sat %0b,",
                              " got position %0d done %0b sat %0b"},
                             want.cell_position, want.step_done, want.saturated,
                             got.cell_position, got.step_done, got.saturated);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_req     i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_res    o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_tracker tracker;
    // Percent of cycles in which the sender idles and the receiver stalls.
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;

    wave_grid_time_step_core #(
        .GRID_COLUMNS(COLS),
        .GRID_ROWS(ROWS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // The receiver decides at each falling edge whether to stall the next
    // rising edge, so the stall never moves around the sampling point.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Results are sampled at the rising edge and handed to the grid model.
    // The watchdog counts edges at which neither channel moves a request or
    // a result, which covers the clearing pass and the longest step.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                tracker.check_result(o_out);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("wave_grid_time_step_core: mismatch");
                    $finish;
                end
            end
        end
    end

    // A register write: setup cycle, then access cycle until pready.
    task automatic write_reg(logic [1:0] idx, bit [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Present one request, idling first at random, and hold it until taken.
    // Valid stays high from one request to the next when no idle is drawn.
    task automatic send_request(t_opcode op, int col, int row, bit [31:0] disp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          = 1'b1;
        i_in.opcode         = op;
        i_in.column         = col[5:0];
        i_in.row            = row[5:0];
        i_in.displacement   = disp;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_request(i_in);
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic wait_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Random requests: about half of them land in a small window so
    // that later reads see earlier adds and steps spread them around.
    task automatic random_requests(int count);
        int      pick;
        int      col;
        int      row;
        t_opcode op;
        bit [31:0] disp;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45)      op = OP_ADD;
            else if (pick < 85) op = OP_READ;
            else if (pick < 93) op = OP_STEP;
            else                op = OP_NONE;
            if ($urandom_range(1)) begin
                col = $urandom_range(36, 28);
                row = $urandom_range(36, 28);
            end else begin
                col = $urandom_range(COLS - 1);
                row = $urandom_range(ROWS - 1);
            end
            if ($urandom_range(3) == 0) disp = $urandom();
            else                        disp = $urandom_range(20, 0) << $urandom_range(18);
            if ($urandom_range(1)) disp = -disp;
            send_request(op, col, row, disp);
            if (n == count / 2 && $urandom_range(1))
                wait_results();
        end
    endtask

    initial begin
        tracker        = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_out_stall    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(REG_GAIN, 32'd65536);
        write_reg(REG_TIMESTEP, 32'd6554);
        write_reg(REG_BOUNDARY, 32'd1);

        // Directed part: field extremes, add saturation in both directions,
        // every opcode, and steps with the stencil on.
        send_request(OP_ADD, 0, 0, 32'h7FFF_FFFF);
        send_request(OP_ADD, 0, 0, 32'h0000_0001);
        send_request(OP_ADD, COLS - 1, ROWS - 1, 32'h8000_0000);
        send_request(OP_ADD, COLS - 1, ROWS - 1, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32, 32, 32'h0001_0000);
        send_request(OP_ADD, 42, 21, 32'hFFFE_0000);
        send_request(OP_READ, 0, 0, 32'hFFFF_FFFF);
        send_request(OP_READ, COLS - 1, ROWS - 1, 32'h0);
        send_request(OP_READ, 42, 21, 32'h0);
        send_request(OP_NONE, COLS - 1, ROWS - 1, 32'hFFFF_FFFF);
        send_request(OP_STEP, 21, 42, 32'h5555_5555);
        send_request(OP_READ, 32, 32, 32'h0);
        send_request(OP_READ, 33, 31, 32'h0);
        send_request(OP_STEP, 0, 0, 32'h0);
        send_request(OP_READ, 0, 0, 32'h0);
        wait_results();

        // Largest gain and time step: the stencil saturates.
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_TIMESTEP, 32'h0000_FFFF);
        send_request(OP_STEP, 0, 0, 32'h0);
        send_request(OP_READ, 32, 32, 32'h0);
        wait_results();

        // Stencil off and zero time step, then stencil off with a real step.
        write_reg(REG_BOUNDARY, 32'd0);
        write_reg(REG_TIMESTEP, 32'd0);
        write_reg(REG_GAIN, 32'd0);
        send_request(OP_STEP, 0, 0, 32'h0);
        send_request(OP_READ, 0, 0, 32'h0);
        wait_results();
        write_reg(REG_TIMESTEP, 32'd3277);
        send_request(OP_STEP, 0, 0, 32'h0);
        send_request(OP_READ, 32, 32, 32'h0);
        wait_results();

        // Random phases, each with its own idling pattern and settings.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            write_reg(REG_GAIN, $urandom_range(32'h0002_0000));
            write_reg(REG_TIMESTEP, $urandom_range(16'hFFFF));
            write_reg(REG_BOUNDARY, (phase != 3) ? 32'd1 : 32'd0);
            random_requests(25);
            wait_results();
        end

        if (tracker.fails == 0 && tracker.pending_results.size() == 0) begin
            $display("wave_grid_time_step_core: match");
        end else begin
            $display("wave_grid_time_step_core: mismatch");
        end
        $finish;
    end

endmodule

/* wave_grid_time_step_core.f */
rtl/wgts_pkg.sv
rtl/wgts_ram.sv
rtl/wave_grid_time_step_core.sv
dv/tb_top.sv
